// ----- design/kolds_pkg.sv -----
// shared types, codes, constants and coefficient tables of the dissipation stencil
`default_nettype none

package kolds_pkg;

  // fixed port field widths
  localparam int SAMPLE_FIELD_W = 32;
  localparam int DISS_W         = 32;
  localparam int POS_W          = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GHOST_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FACE_FLAGS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING = 3'd3;

  localparam logic [8:0]  RST_LINE_LENGTH = 9'd32;
  localparam logic [2:0]  RST_GHOST_WIDTH = 3'd3;
  localparam logic [1:0]  RST_FACE_FLAGS  = 2'd0;
  localparam logic [31:0] RST_INV_SPACING = 32'd65536;

  localparam logic [2:0] GHOST_MIN = 3'd3;
  localparam logic [2:0] GHOST_MAX = 3'd5;
  localparam int LINE_MIN = 16;

  // stencil
  localparam int TAPS   = 7;
  localparam int COEF_W = 6;
  localparam int DIV_W  = 6;
  localparam int DIGITS_PER_STAGE = 4;

  // interior: divide by 64 * 2^16; closures: divide by 4*m * 2^16 with m = 59, 43, 49
  localparam int SHIFT_MID  = 22;
  localparam int SHIFT_EDGE = 18;

  // odd part of the divisor, one for the interior
  localparam logic [DIV_W-1:0] DIV_UNIT  = 6'd1;
  localparam logic [DIV_W-1:0] DIV_FACE0 = 6'd59;
  localparam logic [DIV_W-1:0] DIV_FACE1 = 6'd43;
  localparam logic [DIV_W-1:0] DIV_FACE2 = 6'd49;

  // floor(y / m) = (y * ceil(2^43 / m)) >> 43, exact for every y below 2^37
  localparam int RCP_SHIFT = 43;
  localparam int RCP_W     = 38;
  localparam logic [63:0] RCP_ONE = 64'd1 << RCP_SHIFT;
  localparam logic [RCP_W-1:0] RCP_FACE0 =
    RCP_W'((RCP_ONE + 64'(DIV_FACE0) - 64'd1) / 64'(DIV_FACE0));
  localparam logic [RCP_W-1:0] RCP_FACE1 =
    RCP_W'((RCP_ONE + 64'(DIV_FACE1) - 64'd1) / 64'(DIV_FACE1));
  localparam logic [RCP_W-1:0] RCP_FACE2 =
    RCP_W'((RCP_ONE + 64'(DIV_FACE2) - 64'd1) / 64'(DIV_FACE2));

  localparam int KIND_W = 3;
  typedef logic [KIND_W-1:0] kolds_kind_t;
  localparam kolds_kind_t KIND_MID = 3'd0;
  localparam kolds_kind_t KIND_L0  = 3'd1;  // left face point
  localparam kolds_kind_t KIND_L1  = 3'd2;
  localparam kolds_kind_t KIND_L2  = 3'd3;
  localparam kolds_kind_t KIND_R0  = 3'd4;  // right face point
  localparam kolds_kind_t KIND_R1  = 3'd5;
  localparam kolds_kind_t KIND_R2  = 3'd6;

  typedef struct packed {
    logic [8:0]  line_length;
    logic [2:0]  ghost_width;
    logic [1:0]  face_flags;
    logic [31:0] inv_spacing;
  } kolds_cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             last;
  } kolds_tag_t;

  typedef struct packed {
    kolds_kind_t kind;
    kolds_tag_t  tag;
  } kolds_desc_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [DIV_W-1:0] div;
    kolds_tag_t       tag;
  } kolds_dctl_t;

  // weights by window slot, slot 0 is the newest sample u[p+3]
  typedef logic [0:TAPS-1][COEF_W-1:0] kolds_coef_row_t;

  function automatic kolds_coef_row_t kolds_coef_row(input kolds_kind_t kind);
    kolds_coef_row_t row;
    unique case (kind)
      KIND_L0: row = '{6'sd1, -6'sd3, 6'sd3, -6'sd1, 6'sd0, 6'sd0, 6'sd0};
      KIND_L1: row = '{6'sd1, -6'sd6, 6'sd12, -6'sd10, 6'sd3, 6'sd0, 6'sd0};
      KIND_L2: row = '{6'sd1, -6'sd6, 6'sd15, -6'sd19, 6'sd12, -6'sd3, 6'sd0};
      KIND_R0: row = '{6'sd0, 6'sd0, 6'sd0, -6'sd1, 6'sd3, -6'sd3, 6'sd1};
      KIND_R1: row = '{6'sd0, 6'sd0, 6'sd3, -6'sd10, 6'sd12, -6'sd6, 6'sd1};
      KIND_R2: row = '{6'sd0, -6'sd3, 6'sd12, -6'sd19, 6'sd15, -6'sd6, 6'sd1};
      // interior with the -1/64 sign folded into the weights
      default: row = '{6'sd1, -6'sd6, 6'sd15, -6'sd20, 6'sd15, -6'sd6, 6'sd1};
    endcase
    return row;
  endfunction

  function automatic logic [DIV_W-1:0] kolds_divisor(input kolds_kind_t kind);
    logic [DIV_W-1:0] m;
    unique case (kind) inside
      KIND_L0, KIND_R0: m = DIV_FACE0;
      KIND_L1, KIND_R1: m = DIV_FACE1;
      KIND_L2, KIND_R2: m = DIV_FACE2;
      default:          m = DIV_UNIT;
    endcase
    return m;
  endfunction

  function automatic logic [RCP_W-1:0] kolds_recip(input logic [DIV_W-1:0] m);
    logic [RCP_W-1:0] r;
    unique case (m)
      DIV_FACE0: r = RCP_FACE0;
      DIV_FACE1: r = RCP_FACE1;
      DIV_FACE2: r = RCP_FACE2;
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/kolds_front.sv -----
// sample window, line position tracking and the seven-tap weighted sum
`default_nettype none

module kolds_front
  import kolds_pkg::*;
#(
  parameter int MAX_LINE = 256,
  parameter int SAMPLE_W = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [SAMPLE_FIELD_W-1:0]  in_sample,
  input  kolds_cfg_t                 cfg,
  output logic                       sum_valid,
  input  logic                       sum_ready,
  output logic signed [SAMPLE_W+5:0] sum,
  output kolds_desc_t                sum_desc
);

  localparam int NW   = $clog2(MAX_LINE);
  localparam int CW   = ((NW + 1 > 9) ? NW + 1 : 9) + 1;
  localparam int PW   = SAMPLE_W + 5;
  localparam int SUMW = SAMPLE_W + 6;

  logic [NW-1:0]               idx_r;
  logic signed [SAMPLE_W-1:0]  win_r [TAPS];
  logic                        v1_r, v2_r, v3_r;
  kolds_desc_t                 desc1_r, desc2_r, desc3_r;
  logic signed [PW-1:0]        prod_r [TAPS];
  logic signed [SUMW-1:0]      sum_r;

  logic                        rdy1, rdy2, rdy3, accept;
  logic [CW-1:0]               len_c, g_e, n_c, p_c, ie_c;
  logic [2:0]                  g_c;
  logic                        hit;
  kolds_desc_t                 desc1_nxt;
  logic [NW-1:0]               idx_nxt;
  logic signed [SAMPLE_W-1:0]  samp;
  kolds_coef_row_t             row;
  logic signed [PW-1:0]        prod_nxt [TAPS];
  logic signed [SUMW-1:0]      sum_nxt;

  assign rdy3     = !v3_r || sum_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign accept   = in_valid && rdy1;

  assign samp = $signed(in_sample[SAMPLE_W-1:0]);

  // clamp the line geometry and classify the position of this beat
  always_comb begin
    len_c = CW'(cfg.line_length);
    if (len_c < CW'(LINE_MIN)) len_c = CW'(LINE_MIN);
    else if (len_c > CW'(MAX_LINE)) len_c = CW'(MAX_LINE);
    g_c = cfg.ghost_width;
    if (g_c < GHOST_MIN) g_c = GHOST_MIN;
    else if (g_c > GHOST_MAX) g_c = GHOST_MAX;
    g_e  = CW'(g_c);
    n_c  = CW'(idx_r);
    p_c  = n_c - CW'(3);
    ie_c = len_c - g_e;
    hit  = (n_c >= CW'(3)) && (p_c >= g_e) && (p_c < ie_c);

    desc1_nxt.kind = KIND_MID;
    if (cfg.face_flags[0]) begin
      if (p_c == g_e) desc1_nxt.kind = KIND_L0;
      else if (p_c == g_e + CW'(1)) desc1_nxt.kind = KIND_L1;
      else if (p_c == g_e + CW'(2)) desc1_nxt.kind = KIND_L2;
    end
    if (cfg.face_flags[1]) begin
      if (p_c == ie_c - CW'(1)) desc1_nxt.kind = KIND_R0;
      else if (p_c == ie_c - CW'(2)) desc1_nxt.kind = KIND_R1;
      else if (p_c == ie_c - CW'(3)) desc1_nxt.kind = KIND_R2;
    end
    desc1_nxt.tag.pos  = p_c[POS_W-1:0];
    desc1_nxt.tag.last = (p_c == ie_c - CW'(1));

    // an index at or past the end (length lowered mid-line) also closes the line
    if (n_c >= len_c - CW'(1)) idx_nxt = '0;
    else idx_nxt = idx_r + NW'(1);
  end

  always_comb begin
    row = kolds_coef_row(desc1_r.kind);
    for (int j = 0; j < TAPS; j++) begin
      prod_nxt[j] = PW'(win_r[j]) * PW'($signed(row[j]));
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int j = 0; j < TAPS; j++) begin
      sum_nxt = sum_nxt + SUMW'(prod_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      for (int j = 0; j < TAPS; j++) win_r[j] <= '0;
    end else begin
      if (accept) begin
        idx_r    <= idx_nxt;
        win_r[0] <= samp;
        for (int j = 1; j < TAPS; j++) win_r[j] <= win_r[j-1];
      end
      if (rdy1) v1_r <= accept && hit;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) desc1_r <= desc1_nxt;
    if (rdy2) begin
      desc2_r <= desc1_r;
      for (int j = 0; j < TAPS; j++) prod_r[j] <= prod_nxt[j];
    end
    if (rdy3) begin
      desc3_r <= desc2_r;
      sum_r   <= sum_nxt;
    end
  end

  assign sum_valid = v3_r;
  assign sum       = sum_r;
  assign sum_desc  = desc3_r;

endmodule

`default_nettype wire

// ----- design/kolds_scale.sv -----
// magnitude, weight, split multiply by the inverse spacing, rounding and overflow check
`default_nettype none

module kolds_scale
  import kolds_pkg::*;
#(
  parameter int SAMPLE_W = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        sum_valid,
  output logic                        sum_ready,
  input  logic signed [SAMPLE_W+5:0]  sum,
  input  kolds_desc_t                 sum_desc,
  input  logic [31:0]                 inv_spacing,
  output logic                        y_valid,
  input  logic                        y_ready,
  output logic [4*((SAMPLE_W+3)/4)+4:0] y,
  output kolds_dctl_t                 y_ctl
);

  localparam int SUMW = SAMPLE_W + 6;
  localparam int MAGW = SAMPLE_W + 5;
  localparam int MW   = SAMPLE_W + 7;
  localparam int PPW  = MW + 16;
  localparam int XW   = MW + 32;
  localparam int QW   = DIGITS_PER_STAGE * ((SAMPLE_W + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE);
  localparam int YW   = QW + 5;

  logic              v4_r, v5_r, v6_r;
  logic              rdy4, rdy5, rdy6;
  logic [MW-1:0]     m4_r;
  logic              neg4_r, neg5_r;
  kolds_desc_t       desc4_r, desc5_r;
  logic [PPW-1:0]    pl_r, ph_r;
  logic [YW-1:0]     y_r;
  kolds_dctl_t       ctl_r;

  logic [SUMW-1:0]   mag_full;
  logic [MAGW-1:0]   mag;
  logic [MW-1:0]     m4_nxt;
  logic [DIV_W-1:0]  div5;
  logic              mid5;
  logic [XW-1:0]     x5, y5, rnd5;
  kolds_dctl_t       ctl_nxt;

  assign rdy6      = !v6_r || y_ready;
  assign rdy5      = !v5_r || rdy6;
  assign rdy4      = !v4_r || rdy5;
  assign sum_ready = rdy4;

  // closures carry a factor of three on top of the sum
  always_comb begin
    mag_full = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
    mag      = mag_full[MAGW-1:0];
    m4_nxt   = MW'(mag);
    if (sum_desc.kind != KIND_MID) m4_nxt = MW'(mag) + (MW'(mag) << 1);
  end

  // round to nearest with ties up, then prescale by the power of two part of the divisor
  always_comb begin
    mid5  = (desc5_r.kind == KIND_MID);
    div5  = kolds_divisor(desc5_r.kind);
    rnd5  = mid5 ? (XW'(div5) << (SHIFT_MID - 1)) : (XW'(div5) << (SHIFT_EDGE - 1));
    x5    = (XW'(ph_r) << 16) + XW'(pl_r) + rnd5;
    y5    = mid5 ? (x5 >> SHIFT_MID) : (x5 >> SHIFT_EDGE);
    ctl_nxt.neg = neg5_r;
    ctl_nxt.ovf = (y5 >= (XW'(div5) << (SAMPLE_W - 1)));
    ctl_nxt.div = div5;
    ctl_nxt.tag = desc5_r.tag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= sum_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      m4_r    <= m4_nxt;
      neg4_r  <= sum[SUMW-1];
      desc4_r <= sum_desc;
    end
    if (rdy5) begin
      pl_r    <= PPW'(m4_r) * PPW'(inv_spacing[15:0]);
      ph_r    <= PPW'(m4_r) * PPW'(inv_spacing[31:16]);
      neg5_r  <= neg4_r;
      desc5_r <= desc4_r;
    end
    if (rdy6) begin
      y_r   <= y5[YW-1:0];
      ctl_r <= ctl_nxt;
    end
  end

  assign y_valid = v6_r;
  assign y       = y_r;
  assign y_ctl   = ctl_r;

endmodule

`default_nettype wire

// ----- design/kolds_div.sv -----
// division by the closure divisors as a reciprocal multiply split in two partial products
`default_nettype none

module kolds_div
  import kolds_pkg::*;
#(
  parameter int SAMPLE_W = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          y_valid,
  output logic                          y_ready,
  input  logic [4*((SAMPLE_W+3)/4)+4:0] y,
  input  kolds_dctl_t                   y_ctl,
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic [4*((SAMPLE_W+3)/4)-1:0] q,
  output kolds_dctl_t                   q_ctl
);

  localparam int QW    = DIGITS_PER_STAGE * ((SAMPLE_W + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE);
  localparam int YW    = QW + 5;
  localparam int LOW_W = 16;
  localparam int HIW   = YW - LOW_W;
  localparam int PLW   = RCP_W + LOW_W;
  localparam int PHW   = RCP_W + HIW;
  localparam int TW    = RCP_W + YW + 1;

  logic              va_r, vb_r;
  logic [PLW-1:0]    pl_r;
  logic [PHW-1:0]    ph_r;
  logic [QW-1:0]     yb_r, q_r;
  kolds_dctl_t       ctl_a_r, ctl_b_r;

  logic              rdy_a, rdy_b;
  logic [RCP_W-1:0]  rcp;
  logic [TW-1:0]     t_c;
  logic [QW-1:0]     q_nxt;

  assign rdy_b   = !vb_r || q_ready;
  assign rdy_a   = !va_r || rdy_b;
  assign y_ready = rdy_a;
  assign rcp     = kolds_recip(y_ctl.div);

  // the interior divides by one and passes the rounded value through
  always_comb begin
    t_c = (TW'(ph_r) << LOW_W) + TW'(pl_r);
    if (ctl_a_r.div == DIV_UNIT) q_nxt = yb_r;
    else q_nxt = t_c[RCP_SHIFT +: QW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= y_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      pl_r    <= PLW'(y[LOW_W-1:0]) * PLW'(rcp);
      ph_r    <= PHW'(y[YW-1:LOW_W]) * PHW'(rcp);
      yb_r    <= y[QW-1:0];
      ctl_a_r <= y_ctl;
    end
    if (rdy_b) begin
      q_r     <= q_nxt;
      ctl_b_r <= ctl_a_r;
    end
  end

  assign q_valid = vb_r;
  assign q       = q_r;
  assign q_ctl   = ctl_b_r;

endmodule

`default_nettype wire

// ----- design/ko_dissipation_line_stencil_top.sv -----
// top level of the sixth-order Kreiss-Oliger dissipation stencil along one grid line
// throughput: one sample beat per cycle while out_tready is held high, with one result beat per interior position
// pipeline: the result for position p, begun at the edge that takes sample p+3, reaches out_tvalid
//   through nine register stages (set by the split spacing multiply and the reciprocal divide)
// reset: rst_n is synchronous, active low; it empties the pipeline, zeroes the window and
//   the line index, and loads the register defaults (length 32, ghost 3, no faces, spacing 1.0)
`default_nettype none

module ko_dissipation_line_stencil_top
  import kolds_pkg::*;
#(
  parameter int MAX_LINE    = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // sample beats
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,    // [31:0] sample_value
  // result beats
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,   // [31:0] dissipation, [39:32] position
  output logic                  out_tlast,   // line_last
  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // the sample field is 32 bits, so wider sample settings behave as 32
  localparam int SAMPLE_W = (SAMPLE_BITS > SAMPLE_FIELD_W) ? SAMPLE_FIELD_W : SAMPLE_BITS;
  localparam int QW = DIGITS_PER_STAGE * ((SAMPLE_W + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE);
  localparam int YW = QW + 5;

  localparam logic [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  kolds_cfg_t cfg_r;

  // front: window and weighted sum
  logic                       sum_valid, sum_ready;
  logic signed [SAMPLE_W+5:0] sum;
  kolds_desc_t                sum_desc;

  // scale: multiply, round, overflow
  logic                       y_valid, y_ready;
  logic [YW-1:0]              y;
  kolds_dctl_t                y_ctl;

  // divider output
  logic                       q_valid, q_ready;
  logic [QW-1:0]              q;
  kolds_dctl_t                q_ctl;

  // result register
  logic                       out_valid_r;
  logic [DISS_W-1:0]          out_diss_r;
  logic [POS_W-1:0]           out_pos_r;
  logic                       out_last_r;
  logic [SAMPLE_W-1:0]        q_sw, res;

  // register file, values masked to their widths, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_length <= RST_LINE_LENGTH;
      cfg_r.ghost_width <= RST_GHOST_WIDTH;
      cfg_r.face_flags  <= RST_FACE_FLAGS;
      cfg_r.inv_spacing <= RST_INV_SPACING;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_LENGTH: cfg_r.line_length <= cfg_wdata[8:0];
        REG_GHOST_WIDTH: cfg_r.ghost_width <= cfg_wdata[2:0];
        REG_FACE_FLAGS:  cfg_r.face_flags  <= cfg_wdata[1:0];
        REG_INV_SPACING: cfg_r.inv_spacing <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  kolds_front #(
    .MAX_LINE (MAX_LINE),
    .SAMPLE_W (SAMPLE_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata),
    .cfg       (cfg_r),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .sum_desc  (sum_desc)
  );

  kolds_scale #(
    .SAMPLE_W (SAMPLE_W)
  ) u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .sum_valid   (sum_valid),
    .sum_ready   (sum_ready),
    .sum         (sum),
    .sum_desc    (sum_desc),
    .inv_spacing (cfg_r.inv_spacing),
    .y_valid     (y_valid),
    .y_ready     (y_ready),
    .y           (y),
    .y_ctl       (y_ctl)
  );

  kolds_div #(
    .SAMPLE_W (SAMPLE_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .y_valid (y_valid),
    .y_ready (y_ready),
    .y       (y),
    .y_ctl   (y_ctl),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q       (q),
    .q_ctl   (q_ctl)
  );

  // sign and saturation; a negative result may reach the most negative code
  always_comb begin
    q_sw = q[SAMPLE_W-1:0];
    if (q_ctl.ovf) res = q_ctl.neg ? SAT_MIN : SAT_MAX;
    else res = q_ctl.neg ? SAMPLE_W'(-q_sw) : q_sw;
  end

  // the result register frees the pipeline as soon as a beat is taken
  assign q_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_ready) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready) begin
      out_diss_r <= DISS_W'($signed(res));
      out_pos_r  <= q_ctl.tag.pos;
      out_last_r <= q_ctl.tag.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pos_r, out_diss_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- tb/sv/tb_ko_dissipation_line_stencil_top.sv -----
// self-checking testbench of the sixth-order dissipation line stencil with its own bit-exact predictor
`default_nettype none

module tb_ko_dissipation_line_stencil_top
  import kolds_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX     = 256;
  // pipeline depth is nine register stages; settle well past it
  localparam int DRAIN_CYCLES = 40;
  localparam time RUN_LIMIT   = 5ms;
  localparam int REPORT_MAX   = 10;

  // rounding divisors: interior 64, closures 4*59, 4*43, 4*49 (with the 3/4 of 48/64 in k)
  localparam logic [63:0] MID_DIV   = 64'd64;
  localparam logic [63:0] CLOSE0_DIV = 64'd236;
  localparam logic [63:0] CLOSE1_DIV = 64'd172;
  localparam logic [63:0] CLOSE2_DIV = 64'd196;
  localparam logic [63:0] CLOSE_K    = 64'd3;

  // face flag bit positions
  localparam int FACE_LEFT  = 0;
  localparam int FACE_RIGHT = 1;

  // idle schedules
  localparam int MODE_SLOW_SINK   = 0;
  localparam int MODE_SLOW_SOURCE = 1;
  localparam int MODE_FREE        = 2;

  typedef enum int {STYLE_RANDOM, STYLE_SMALL, STYLE_SMOOTH, STYLE_EXTREME} sample_style_t;

  typedef struct packed {
    logic [31:0] diss;
    logic [7:0]  pos;
    logic        last;
  } stencil_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // sample beats waiting to be sent, and dissipation results still owed by the block
  logic [31:0]     pending_samples [$];
  stencil_result_t owed_results [$];

  logic in_fire = 1'b0;
  int   stall_mode = MODE_SLOW_SINK;
  int   failures = 0;

  // predictor copy of the block: seven-sample window (slot 0 newest), line index, registers
  longint      win [0:6];
  int unsigned line_idx;
  logic [8:0]  model_len;
  logic [2:0]  model_ghost;
  logic [1:0]  model_faces;
  logic [31:0] model_inv;

  ko_dissipation_line_stencil_top #(
    .MAX_LINE    (LINE_MAX),
    .SAMPLE_BITS (32)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // round(sum * k * inv / (d * 2^16)), ties away from zero, sign flipped by flip, saturated
  function automatic logic [31:0] round_scaled(input longint sum, input logic [63:0] k,
                                               input logic [63:0] d, input bit flip,
                                               input logic [31:0] inv);
    logic [63:0] mag, hi, lo, q;
    bit minus;
    mag   = (sum < 0) ? 64'(-sum) : 64'(sum);
    minus = (sum < 0) ^ flip;
    mag   = mag * k;
    // inverse spacing split in halves keeps the product inside 64 bits
    hi = mag * {48'd0, inv[31:16]};
    lo = mag * {48'd0, inv[15:0]} + (d << 15);
    q  = (hi + (lo >> 16)) / d;
    if (minus) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // shift one sample into the window and work out the result it completes, if any
  task automatic advance_line(input logic [31:0] sample, output bit has_result,
                              output stencil_result_t res);
    int unsigned len, g, n, p, stop_at;
    longint u [-3:3];
    int k;
    len = model_len;
    if (len < LINE_MIN) len = LINE_MIN;
    if (len > LINE_MAX) len = LINE_MAX;
    g = model_ghost;
    if (g < GHOST_MIN) g = GHOST_MIN;
    if (g > GHOST_MAX) g = GHOST_MAX;
    n = line_idx;
    for (k = 6; k > 0; k--) win[k] = win[k-1];
    win[0] = longint'($signed(sample));
    // u[k] is the sample at p+k
    for (k = -3; k <= 3; k++) u[k] = win[3-k];
    has_result = 1'b0;
    res = '0;
    if (n >= 3) begin
      p = n - 3;
      stop_at = len - g;
      if (p >= g && p < stop_at) begin
        res.diss = round_scaled(-u[-3] + 6*u[-2] - 15*u[-1] + 20*u[0] - 15*u[1] + 6*u[2]
                                - u[3], 64'd1, MID_DIV, 1'b1, model_inv);
        if (model_faces[FACE_LEFT]) begin
          if (p == g)
            res.diss = round_scaled(u[3] - 3*u[2] + 3*u[1] - u[0],
                                    CLOSE_K, CLOSE0_DIV, 1'b0, model_inv);
          else if (p == g + 1)
            res.diss = round_scaled(u[3] - 6*u[2] + 12*u[1] - 10*u[0] + 3*u[-1],
                                    CLOSE_K, CLOSE1_DIV, 1'b0, model_inv);
          else if (p == g + 2)
            res.diss = round_scaled(u[3] - 6*u[2] + 15*u[1] - 19*u[0] + 12*u[-1] - 3*u[-2],
                                    CLOSE_K, CLOSE2_DIV, 1'b0, model_inv);
        end
        // right closure wins where both faces reach the same point
        if (model_faces[FACE_RIGHT]) begin
          if (p == stop_at - 3)
            res.diss = round_scaled(u[-3] - 6*u[-2] + 15*u[-1] - 19*u[0] + 12*u[1] - 3*u[2],
                                    CLOSE_K, CLOSE2_DIV, 1'b0, model_inv);
          else if (p == stop_at - 2)
            res.diss = round_scaled(u[-3] - 6*u[-2] + 12*u[-1] - 10*u[0] + 3*u[1],
                                    CLOSE_K, CLOSE1_DIV, 1'b0, model_inv);
          else if (p == stop_at - 1)
            res.diss = round_scaled(u[-3] - 3*u[-2] + 3*u[-1] - u[0],
                                    CLOSE_K, CLOSE0_DIV, 1'b0, model_inv);
        end
        res.pos  = p[7:0];
        res.last = (p == stop_at - 1);
        has_result = 1'b1;
      end
    end
    // an index already past the end, after a shortened line, also wraps
    line_idx = (n >= len - 1) ? 0 : n + 1;
  endtask

  task automatic note_failure(input string what);
    failures++;
    if (failures <= REPORT_MAX) $display("[%0t] %s", $realtime, what);
  endtask

  // sender: holds a beat until taken, otherwise offers the next one unless idling
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      out_tready <= 1'b0;
    end else begin
      if (!(in_tvalid && !in_fire)) begin
        if (in_fire) void'(pending_samples.pop_front());
        if (pending_samples.size() > 0 &&
            !(stall_mode == MODE_SLOW_SINK   && $urandom_range(99) < 17) &&
            !(stall_mode == MODE_SLOW_SOURCE && $urandom_range(99) < 82)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_samples[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      // receiver back-pressure
      case (stall_mode)
        MODE_SLOW_SINK:   out_tready <= ($urandom_range(99) >= 82);
        MODE_SLOW_SOURCE: out_tready <= ($urandom_range(99) >= 17);
        default:          out_tready <= 1'b1;
      endcase
    end
  end

  // monitor: predicts on every taken sample beat, checks every taken result beat
  always @(posedge clk) begin : monitor
    bit has;
    stencil_result_t want;
    stencil_result_t head;
    if (!rst_n) begin
      in_fire <= 1'b0;
      foreach (win[i]) win[i] = 0;
      line_idx    = 0;
      model_len   = RST_LINE_LENGTH;
      model_ghost = RST_GHOST_WIDTH;
      model_faces = RST_FACE_FLAGS;
      model_inv   = RST_INV_SPACING;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        advance_line(in_tdata, has, want);
        if (has) owed_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          note_failure($sformatf("unexpected result beat: diss %h pos %0d last %b",
                                 out_tdata[31:0], out_tdata[39:32], out_tlast));
        end else begin
          head = owed_results.pop_front();
          if (out_tdata[31:0] !== head.diss || out_tdata[39:32] !== head.pos ||
              out_tlast !== head.last)
            note_failure($sformatf(
              "mismatch: diss exp %h got %h, pos exp %0d got %0d, last exp %b got %b",
              head.diss, out_tdata[31:0], head.pos, out_tdata[39:32], head.last, out_tlast));
        end
      end
      // register writes land in the predictor on the same edge as in the block
      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_LENGTH: model_len   = cfg_wdata[8:0];
          REG_GHOST_WIDTH: model_ghost = cfg_wdata[2:0];
          REG_FACE_FLAGS:  model_faces = cfg_wdata[1:0];
          REG_INV_SPACING: model_inv   = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // wait for every beat sent and every result back, then let the pipeline empty
  task automatic wait_quiet();
    while (pending_samples.size() > 0 || in_tvalid || owed_results.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  int phase_no = 0;

  // reprogram all registers while idle, then queue one run of samples
  task automatic run_phase(input logic [31:0] len, input logic [31:0] ghost,
                           input logic [31:0] faces, input logic [31:0] inv,
                           input int count, input sample_style_t style);
    int c0, c1, c2;
    logic [31:0] s;
    wait_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LINE_LENGTH;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_index <= REG_GHOST_WIDTH;
    cfg_wdata <= ghost;
    @(negedge clk);
    cfg_index <= REG_FACE_FLAGS;
    cfg_wdata <= faces;
    @(negedge clk);
    cfg_index <= REG_INV_SPACING;
    cfg_wdata <= inv;
    @(negedge clk);
    // index past the last register, must change nothing
    cfg_index <= CFG_IDX_W'(REG_INV_SPACING + 1 + $urandom_range(3));
    cfg_wdata <= $urandom;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    phase_no++;
    stall_mode = (phase_no < 6) ? MODE_SLOW_SINK :
                 (phase_no < 11) ? MODE_SLOW_SOURCE : MODE_FREE;
    c0 = int'($urandom_range(1 << 20)) - (1 << 19);
    c1 = int'($urandom_range(4096)) - 2048;
    c2 = int'($urandom_range(1024)) - 512;
    for (int i = 0; i < count; i++) begin
      case (style)
        STYLE_SMALL:  s = 32'($urandom_range(8191)) - 32'd4096;
        // low-order polynomial plus a little noise: closures see small differences
        STYLE_SMOOTH: s = 32'(c0 + c1 * i + c2 * i * i + int'($urandom_range(3)));
        STYLE_EXTREME: begin
          case ($urandom_range(5))
            0: s = 32'h7FFF_FFFF;
            1: s = 32'h8000_0000;
            2: s = 32'h0000_0000;
            3: s = 32'h0000_0001;
            4: s = 32'hFFFF_FFFF;
            default: s = $urandom;
          endcase
        end
        default: s = $urandom;
      endcase
      pending_samples.push_back(s);
    end
  endtask

  initial begin : stimulus
    logic [31:0] len_v, inv_v;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: alternating full-scale samples saturate the interior, then single
    // spikes that land on a rounding tie, and the smallest nonzero values
    pending_samples = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                        32'h0000_0000, 32'h0000_0008, 32'h0000_0000, 32'h0000_0000,
                        32'h0000_0000, 32'hFFFF_FFF8, 32'h0000_0000, 32'h0000_0000,
                        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF};

    run_phase(32'd32, 32'd3, 32'd0, 32'h0001_0000, 80, STYLE_RANDOM);
    // shortest line, both closures
    run_phase(32'd16, 32'd3, 32'd3, 32'h0001_0000, 60, STYLE_SMOOTH);
    // high bits masked off: length 16, ghost 5, largest spacing factor
    run_phase(32'h0001_FE10, 32'hFFFF_FFFD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 70, STYLE_EXTREME);
    run_phase(32'd256, 32'd5, 32'd3, $urandom, 150, STYLE_RANDOM);
    // length and ghost clamped up, zero spacing; shortening ends the line in progress
    run_phase(32'd0, 32'd0, 32'd1, 32'd0, 40, STYLE_RANDOM);
    // length and ghost clamped down
    run_phase(32'd511, 32'd7, 32'd2, 32'h0001_0000, 120, STYLE_SMOOTH);
    run_phase(32'd17, 32'd4, 32'd3, 32'd3, 60, STYLE_SMALL);

    for (int r = 0; r < 8; r++) begin
      if ($urandom_range(9) < 6)  len_v = $urandom_range(16, 40);
      else if ($urandom_range(1)) len_v = $urandom_range(511);
      else                        len_v = $urandom;
      case ($urandom_range(2))
        0:       inv_v = $urandom;
        1:       inv_v = 32'h0001_0000 + $urandom_range(4095) - 32'd2048;
        default: inv_v = $urandom_range(255);
      endcase
      run_phase(len_v, $urandom, $urandom, inv_v, $urandom_range(55, 85),
                sample_style_t'($urandom_range(3)));
    end

    wait_quiet();
    if (owed_results.size() > 0)
      note_failure($sformatf("%0d results never arrived", owed_results.size()));
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hard stop if the handshakes hang
  initial begin
    #(RUN_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
